// ===== rtl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// shared constants and types for the sliding window maximum block
// ----------------------------------------------------------------------------
package swm_pkg;

    // defaults for the top level parameters
    localparam int MAX_WINDOW_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // width of the window register and of the sample counter
    localparam int WIN_W     = 7;
    localparam int WIN_LIMIT = 1 << WIN_W;

    // sample counter saturates here
    localparam logic [WIN_W-1:0] SEEN_MAX = {WIN_W{1'b1}};

    // control broadcast to every cell of the chain; the head cell gets clear tied low
    typedef struct packed {
        logic             shift;   // a word is taken this cycle
        logic             clear;   // sequence restart, drop the candidate
        logic [WIN_W-1:0] win;     // effective window length, 1..max
    } cell_ctrl_t;

endpackage

// ===== rtl/sliding_window_maximum.sv =====
// ----------------------------------------------------------------------------
// sliding_window_maximum
// running maximum over the last window_size signed samples of a stream
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid/in_ready carries one word: sample plus first flag;
//   first restarts the sequence, dropping all candidates and the sample count
//   output channel out_valid/out_ready carries window_max, one word per input
//   word once window_size samples of the sequence have been seen, none before
//   cfg_wr_en/cfg_wr_data write window_size (0 acts as 1, above the chain
//   length acts as the chain length); write it only while the block is idle
// throughput and latency
//   one word per cycle; out_valid rises at the clock edge after the one that
//   takes the input word (the word lands in the cell chain at the accepting
//   edge, the front select feeds the output register at the next edge)
// reset
//   all candidates dropped, sample count zero, window_size back to 1
// stall
//   a stalled output holds its word; one more result may wait in the pending
//   stage, after which in_ready drops until the receiver takes the output
// ----------------------------------------------------------------------------
module sliding_window_maximum #(
    parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [swm_pkg::WIN_W-1:0]      cfg_wr_data,
    // input words
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           first,
    // result words
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] window_max
);

    // window register and its clamped form
    logic [swm_pkg::WIN_W-1:0] window_size_reg;
    logic [swm_pkg::WIN_W-1:0] win_eff;

    // sample count of the current sequence
    logic [swm_pkg::WIN_W-1:0] seen_reg;
    logic [swm_pkg::WIN_W-1:0] seen_next;
    logic [swm_pkg::WIN_W-1:0] seen_base;

    // handshake and output staging
    logic                           accept;
    logic                           out_free;
    logic                           has_result;
    logic                           pend_reg;
    logic                           pend_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] window_max_reg;

    // cell chain, cell i holds the sample of age i
    swm_pkg::cell_ctrl_t            ctrl;
    logic                           cell_keep  [MAX_WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] cell_value [MAX_WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] front;

    // zero acts as one, too large acts as the chain length
    always_comb
    begin
        win_eff = window_size_reg;
        if (window_size_reg == '0)
        begin
            win_eff = swm_pkg::WIN_W'(1);
        end
        else if ((MAX_WINDOW < swm_pkg::WIN_LIMIT) &&
                 (window_size_reg > swm_pkg::WIN_W'(MAX_WINDOW)))
        begin
            win_eff = swm_pkg::WIN_W'(MAX_WINDOW);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= swm_pkg::WIN_W'(1);
        end
        else if (cfg_wr_en)
        begin
            window_size_reg <= cfg_wr_data;
        end
    end

    // the output register is free when empty or being drained this cycle;
    // the pending stage may then move, so a new word can come in
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !pend_reg || out_free;
    assign accept   = in_valid && in_ready;

    // saturating count, restarted by first
    assign seen_base  = first ? '0 : seen_reg;
    assign seen_next  = (seen_base == swm_pkg::SEEN_MAX) ? seen_base
                                                         : seen_base + swm_pkg::WIN_W'(1);
    assign has_result = (seen_next >= win_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (accept)
        begin
            seen_reg <= seen_next;
        end
    end

    // broadcast to the cells
    assign ctrl.shift = accept;
    assign ctrl.clear = first;
    assign ctrl.win   = win_eff;

    genvar i;
    generate
        for (i = 0; i < MAX_WINDOW; i++)
        begin : g_cell
            swm_pkg::cell_ctrl_t            cell_ctrl;
            logic signed [SAMPLE_WIDTH-1:0] prev_value;
            logic                           prev_keep;

            if (i == 0)
            begin : g_head
                // the new sample always joins as the youngest candidate
                assign cell_ctrl  = '{shift: ctrl.shift, clear: 1'b0, win: ctrl.win};
                assign prev_value = sample;
                assign prev_keep  = 1'b1;
            end
            else
            begin : g_body
                assign cell_ctrl  = ctrl;
                assign prev_value = cell_value[i-1];
                assign prev_keep  = cell_keep[i-1];
            end

            swm_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .INDEX        (i)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .sample     (sample),
                .prev_value (prev_value),
                .prev_keep  (prev_keep),
                .value      (cell_value[i]),
                .keep       (cell_keep[i])
            );
        end
    endgenerate

    // oldest live candidate is the largest in the window
    swm_front_sel #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .N            (MAX_WINDOW)
    ) u_front_sel (
        .keep  (cell_keep),
        .value (cell_value),
        .front (front)
    );

    // pending stage: the chain already holds the state of the pending word
    always_comb
    begin
        pend_next = pend_reg;
        if (accept)
        begin
            pend_next = has_result;
        end
        else if (out_free)
        begin
            pend_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // front is read before a word taken in the same cycle lands in the chain
    always_ff @(posedge clk)
    begin
        if (out_free && pend_reg)
        begin
            window_max_reg <= front;
        end
    end

    assign out_valid  = out_valid_reg;
    assign window_max = window_max_reg;

endmodule

// ===== rtl/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell
// one position of the sample shift chain with its candidate flag
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int INDEX        = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  swm_pkg::cell_ctrl_t            ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic signed [SAMPLE_WIDTH-1:0] prev_value,
    input  logic                           prev_keep,
    output logic signed [SAMPLE_WIDTH-1:0] value,
    output logic                           keep
);

    logic signed [SAMPLE_WIDTH-1:0] value_reg;
    logic                           keep_reg;
    logic                           keep_next;
    logic                           in_win;

    // position equals age after the shift; at or past the window it expires
    assign in_win = (INDEX < swm_pkg::WIN_LIMIT) ?
                    (swm_pkg::WIN_W'(INDEX) < ctrl.win) : 1'b0;

    // a newer strictly larger sample knocks the candidate out
    assign keep_next = prev_keep && (prev_value >= sample) && in_win && !ctrl.clear;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            keep_reg <= keep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            value_reg <= prev_value;
        end
    end

    assign value = value_reg;
    assign keep  = keep_reg;

endmodule

// ===== rtl/swm_front_sel.sv =====
// ----------------------------------------------------------------------------
// swm_front_sel
// picks the value of the oldest live cell through a binary select tree
// ----------------------------------------------------------------------------
module swm_front_sel #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int N            = swm_pkg::MAX_WINDOW_DEF
) (
    input  logic                           keep  [N],
    input  logic signed [SAMPLE_WIDTH-1:0] value [N],
    output logic signed [SAMPLE_WIDTH-1:0] front
);

    localparam int LEVELS = $clog2(N);
    localparam int P      = 1 << LEVELS;

    // heap layout: node k has children 2k+1 (younger) and 2k+2 (older)
    logic                           node_any [2*P-1];
    logic signed [SAMPLE_WIDTH-1:0] node_val [2*P-1];

    genvar j, k;
    generate
        for (j = 0; j < P; j++)
        begin : g_leaf
            if (j < N)
            begin : g_used
                assign node_any[P-1+j] = keep[j];
                assign node_val[P-1+j] = value[j];
            end
            else
            begin : g_pad
                assign node_any[P-1+j] = 1'b0;
                assign node_val[P-1+j] = '0;
            end
        end
        for (k = 0; k < P-1; k++)
        begin : g_node
            assign node_any[k] = node_any[2*k+1] | node_any[2*k+2];
            assign node_val[k] = node_any[2*k+2] ? node_val[2*k+2] : node_val[2*k+1];
        end
    endgenerate

    assign front = node_val[0];

endmodule

// ===== rtl/swm_checker.sv =====
// ----------------------------------------------------------------------------
// swm_checker
// port level checks for the sliding window maximum block
// ----------------------------------------------------------------------------
module swm_checker #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic signed [SAMPLE_WIDTH-1:0] window_max
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(window_max))
        else $error("result word changed while stalled");

    // a fresh result needs an input word taken earlier, through the pending stage
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result word without an input word");

    // input backpressure only comes from a stalled output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while output is free");

endmodule

bind sliding_window_maximum swm_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .window_max (window_max)
);
